/* rtl/ipv_pkg.sv */
package ipv_pkg;

    localparam int CharWidth = 8;

    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharNine  = 8'h39;
    localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
    localparam logic [CharWidth-1:0] CharLowF  = 8'h66;
    localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
    localparam logic [CharWidth-1:0] CharUpF   = 8'h46;
    localparam logic [CharWidth-1:0] CharDot   = 8'h2E;
    localparam logic [CharWidth-1:0] CharColon = 8'h3A;

    localparam logic [5:0] MinLen        = 6'd7;
    localparam logic [5:0] MaxLen        = 6'd39;
    localparam logic [9:0] V4MaxValue    = 10'd255;
    localparam logic [9:0] GroupValueMax = 10'd999;
    localparam logic [3:0] V4Groups      = 4'd4;
    localparam logic [3:0] V6Groups      = 4'd8;
    localparam logic [2:0] V4MaxDigits   = 3'd3;
    localparam logic [2:0] V6MaxDigits   = 3'd4;

    typedef enum logic [1:0] {
        VERDICT_NEITHER = 2'd0,
        VERDICT_IPV4    = 2'd1,
        VERDICT_IPV6    = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [5:0] char_count;
        logic       dot_seen;
        logic       colon_seen;
        logic [3:0] group_count;
        logic [2:0] group_length;
        logic [9:0] group_value;
        logic       group_has_non_decimal;
        logic       leading_zero;
        logic       error_flag;
    } ipv_state_t;

    // Checks the open group against the separator kind, counts it and clears it.
    function automatic ipv_state_t close_group(input ipv_state_t s, input logic v4);
        ipv_state_t r;
        r = s;
        if (s.group_length == 3'd0)
        begin
            r.error_flag = 1'b1;
        end
        else if (v4)
        begin
            if (s.group_has_non_decimal || (s.group_length > V4MaxDigits) ||
                (s.group_value > V4MaxValue) ||
                (s.leading_zero && (s.group_length > 3'd1)))
            begin
                r.error_flag = 1'b1;
            end
        end
        else if (s.group_length > V6MaxDigits)
        begin
            r.error_flag = 1'b1;
        end
        if (s.group_count != '1)
        begin
            r.group_count = s.group_count + 4'd1;
        end
        r.group_length          = '0;
        r.group_value           = '0;
        r.group_has_non_decimal = 1'b0;
        r.leading_zero          = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/ipv_char_if.sv */
interface ipv_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink (input valid, input char_code, input is_last, output ready);
endinterface

/* rtl/ipv_verdict_if.sv */
interface ipv_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface

/* rtl/ipv_step.sv */
module ipv_step
    import ipv_pkg::*;
(
    input  ipv_state_t     st,
    input  logic [7:0]     char_code,
    input  logic           is_last,
    output ipv_state_t     st_next,
    output verdict_t       verdict
);

    ipv_state_t  s;
    ipv_state_t  c;
    logic [13:0] value_ext;
    logic        v4;
    logic        v6;

    assign value_ext = ({4'd0, st.group_value} << 3) + ({4'd0, st.group_value} << 1)
                     + {10'd0, char_code[3:0]};

    always_comb
    begin
        s       = st;
        c       = st;
        v4      = 1'b0;
        v6      = 1'b0;
        verdict = VERDICT_NEITHER;

        if (st.char_count != '1)
        begin
            s.char_count = st.char_count + 6'd1;
        end

        case (char_code) inside
            CharDot:
            begin
                s.dot_seen = 1'b1;
                s = close_group(s, 1'b1);
            end
            CharColon:
            begin
                s.colon_seen = 1'b1;
                s = close_group(s, 1'b0);
            end
            [CharZero:CharNine]:
            begin
                if ((st.group_length == 3'd0) && (char_code == CharZero))
                begin
                    s.leading_zero = 1'b1;
                end
                if (st.group_length != '1)
                begin
                    s.group_length = st.group_length + 3'd1;
                end
                if (value_ext > {4'd0, GroupValueMax})
                begin
                    s.group_value = GroupValueMax;
                end
                else
                begin
                    s.group_value = value_ext[9:0];
                end
            end
            [CharLowA:CharLowF], [CharUpA:CharUpF]:
            begin
                if (st.group_length != '1)
                begin
                    s.group_length = st.group_length + 3'd1;
                end
                s.group_has_non_decimal = 1'b1;
            end
            default:
            begin
                s.error_flag = 1'b1;
            end
        endcase

        if (is_last)
        begin
            v4 = s.dot_seen && !s.colon_seen;
            v6 = s.colon_seen && !s.dot_seen;
            if (v4 || v6)
            begin
                c = close_group(s, v4);
                if (!c.error_flag && (c.char_count >= MinLen) && (c.char_count <= MaxLen))
                begin
                    if (v4 && (c.group_count == V4Groups))
                    begin
                        verdict = VERDICT_IPV4;
                    end
                    else if (v6 && (c.group_count == V6Groups))
                    begin
                        verdict = VERDICT_IPV6;
                    end
                end
            end
            st_next = '0;
        end
        else
        begin
            st_next = s;
        end
    end

endmodule

/* rtl/ip_address_text_validator.sv */
// Channel    Role    Payload               Item accepted
// chars      sink    char_code, is_last    valid && ready at a rising clk edge
// verdicts   source  verdict               valid && ready at a rising clk edge
//
// One character item is accepted per cycle unless a string end waits on a stalled output.
// The verdict becomes valid at the edge that moves the closing character out of the input
// register, through the per-character update and into the output register.
// rst_n clears the string state and both valid flags, so a new string starts cleanly.
// Only an item that ends a string waits on a stalled output; other characters keep flowing.
module ip_address_text_validator
    import ipv_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    ipv_char_if.sink     chars,
    ipv_verdict_if.source verdicts
);

    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;
    ipv_state_t state_reg;
    ipv_state_t state_next;
    verdict_t   verdict_next;
    logic       out_valid_reg;
    verdict_t   out_verdict_reg;
    logic       out_free;
    logic       s1_go;

    assign out_free    = !out_valid_reg || verdicts.ready;
    assign s1_go       = s1_valid_reg && (!s1_last_reg || out_free);
    assign chars.ready = !s1_valid_reg || s1_go;

    assign verdicts.valid   = out_valid_reg;
    assign verdicts.verdict = out_verdict_reg;

    ipv_step u_step (
        .st        (state_reg),
        .char_code (s1_char_reg),
        .is_last   (s1_last_reg),
        .st_next   (state_next),
        .verdict   (verdict_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            s1_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg <= chars.char_code;
            s1_last_reg <= chars.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_go)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdicts.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            out_verdict_reg <= verdict_next;
        end
    end

    // The string state is cleared once its verdict has been produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> (state_reg == '0))
        else $error("string state not cleared after a verdict");

    // Input back-pressure comes only from a string end waiting on a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !chars.ready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !verdicts.ready))
        else $error("input stalled without a waiting verdict");

    // No group or separator can be recorded before any character of the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.char_count == 6'd0) |->
            ((state_reg.group_count == 4'd0) && !state_reg.dot_seen && !state_reg.colon_seen))
        else $error("group state present with an empty string");

endmodule
